/* hdl/assert_macros.svh */
// Assertion helpers used by lz_binary_rans_decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hdl/lzbr_pkg.sv */
// ----------------------------------------------------------------------------
// lzbr_pkg
// Constants and codes of the LZ binary rANS decompressor.
// ----------------------------------------------------------------------------
`default_nettype none
package lzbr_pkg;
    localparam int HISTORY_DEPTH_DEF = 32768;
    localparam int NUM_CTX        = 385;
    localparam int CTX_W          = 9;
    localparam int P_FRAC_W       = 8;
    localparam int ADAPT_SHIFT    = 4;
    localparam int ADAPT_BIAS     = 8;
    localparam logic [8:0] CX_MATCH_FLAG = 9'd0;
    localparam logic [8:0] CX_FRESH_DIST = 9'd256;
    localparam logic [8:0] CX_DIST_BASE  = 9'd257;
    localparam logic [8:0] CX_RUN_BASE   = 9'd321;
    localparam logic [19:0] REFILL_LIMIT  = 20'd4096;
    localparam logic [31:0] LIMIT_RESET   = 32'd536870912;
    localparam logic [7:0]  PROB_INIT     = 8'd128;

    typedef enum logic [1:0] {
        FN_BYTE = 2'd0,
        FN_STEP = 2'd1,
        FN_END  = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    localparam logic [2:0] ST_WORKING   = 3'd0;
    localparam logic [2:0] ST_NEED_BYTE = 3'd1;
    localparam logic [2:0] ST_FINISHED  = 3'd2;
    localparam logic [2:0] ST_OFFSET    = 3'd3;
    localparam logic [2:0] ST_SIZE      = 3'd4;
    localparam logic [2:0] ST_LENGTH    = 3'd5;
    localparam logic [2:0] ST_EARLY_END = 3'd6;
    localparam logic [2:0] ST_DROPPED   = 3'd7;
endpackage
`default_nettype wire

/* hdl/lzbr_ram.sv */
// ----------------------------------------------------------------------------
// lzbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lzbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/lz_binary_rans_decompressor.sv */
// ----------------------------------------------------------------------------
// lz_binary_rans_decompressor
// Streaming LZ decoder with an adaptive binary rANS entropy stage.
// ----------------------------------------------------------------------------
// Each command word is handled thus: in the accept cycle the probability and
// history memories are read, in the next cycle the coder value is updated,
// the probability is written back and the result word is loaded into the
// output register. A new command is taken once no word is in flight and that
// register is free or being taken, so a word is never taken before the last
// one is done. After reset a clearing pass sets all 385 probabilities to
// 128; no command is accepted during it, while writes to the output limit
// register are taken at any time.
`default_nettype none
`include "assert_macros.svh"
module lz_binary_rans_decompressor #(
    parameter int HISTORY_DEPTH = lzbr_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic      [7:0]  o_out_byte,
    output logic             o_out_valid,
    output logic      [2:0]  o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import lzbr_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(HISTORY_DEPTH);
    localparam logic [31:0]   DEPTH_32  = 32'(HISTORY_DEPTH);
    localparam logic [CTX_W-1:0] CLR_LAST = CTX_W'(NUM_CTX - 1);

    typedef enum logic [2:0] {
        PH_ISMATCH, PH_NEWOFF, PH_LIT, PH_OFF_CONT,
        PH_OFF_VAL, PH_LEN_CONT, PH_LEN_VAL, PH_COPY
    } t_phase;

    logic [31:0]      r_limit;
    logic [19:0]      r_coder, n_coder;
    logic [31:0]      r_produced, n_produced;
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [31:0]      r_offset, n_offset;
    logic             r_off_known, n_off_known;
    logic             r_prev_match, n_prev_match;
    t_phase           r_phase, n_phase;
    logic [CTX_W-1:0] r_ctx, n_ctx;
    logic [31:0]      r_field, n_field;
    logic [5:0]       r_bitpos, n_bitpos;
    logic [31:0]      r_remain, n_remain;
    logic [2:0]       r_sticky, n_sticky;
    logic             r_ended, n_ended;

    logic             r_busy;
    t_func            r_func;
    logic [7:0]       r_byte;
    logic             r_clr_done;
    logic [CTX_W-1:0] r_clr_cnt;
    logic             r_res_valid;
    logic [7:0]       r_obyte;
    logic             r_oval;
    logic [2:0]       r_ostat;
    // Probability address of the word in flight.
    logic [CTX_W-1:0] r_prob_addr;

    logic             accept;
    logic [CTX_W-1:0] prob_raddr, prob_waddr;
    logic [7:0]       prob_rdata, prob_wdata;
    logic             prob_we;
    logic [AW-1:0]    hist_raddr;
    logic [7:0]       hist_rdata, hist_wdata;
    logic             hist_we;
    logic [AW:0]      rd_off, rd_ptr;

    logic             dec_en, dec_bit;
    logic [7:0]       p, low, new_p;
    logic [8:0]       factor;
    logic [20:0]      product;
    logic [31:0]      gam_v;
    logic [CTX_W-1:0] lit_ctx;
    logic [32:0]      end_count;
    logic [7:0]       n_obyte;
    logic             n_oval;
    logic [2:0]       n_ostat;

    assign accept      = i_cmd_valid && !o_cmd_stall;
    assign o_cmd_stall = !(r_clr_done && !r_busy && (!r_res_valid || !i_res_stall));
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_out_byte  = r_obyte;
    assign o_out_valid = r_oval;
    assign o_status    = r_ostat;

    // Read addresses come from the state as it stands at accept time.
    always_comb begin
        case (r_phase)
            PH_ISMATCH: prob_raddr = CX_MATCH_FLAG;
            PH_NEWOFF:  prob_raddr = CX_FRESH_DIST;
            PH_OFF_VAL, PH_LEN_VAL: prob_raddr = r_ctx + 9'd1;
            default:    prob_raddr = r_ctx;
        endcase
        rd_off = r_offset[AW:0];
        if ({1'b0, r_wptr} >= rd_off) begin
            rd_ptr = {1'b0, r_wptr} - rd_off;
        end else begin
            rd_ptr = {1'b0, r_wptr} + DEPTH_W - rd_off;
        end
        hist_raddr = rd_ptr[AW-1:0];
    end

    lzbr_ram #(.WIDTH(8), .DEPTH(NUM_CTX)) u_prob (
        .i_clk(i_clk), .i_we(prob_we), .i_waddr(prob_waddr), .i_wdata(prob_wdata),
        .i_raddr(prob_raddr), .o_rdata(prob_rdata)
    );

    lzbr_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(r_wptr), .i_wdata(hist_wdata),
        .i_raddr(hist_raddr), .o_rdata(hist_rdata)
    );

    // Bit decision and probability update.
    always_comb begin
        p       = prob_rdata;
        low     = r_coder[P_FRAC_W-1:0];
        dec_bit = low < p;
        factor  = dec_bit ? {1'b0, p} : (9'd256 - {1'b0, p});
        product = {12'd0, factor} * {9'd0, r_coder[19:8]};
        if (dec_bit) begin
            new_p = p + 8'((9'd256 - {1'b0, p} + 9'(ADAPT_BIAS)) >> ADAPT_SHIFT);
        end else begin
            new_p = p - 8'(({1'b0, p} + 9'(ADAPT_BIAS)) >> ADAPT_SHIFT);
        end
    end

    always_comb begin
        n_coder = r_coder; n_produced = r_produced; n_wptr = r_wptr;
        n_offset = r_offset; n_off_known = r_off_known; n_prev_match = r_prev_match;
        n_phase = r_phase; n_ctx = r_ctx; n_field = r_field; n_bitpos = r_bitpos;
        n_remain = r_remain; n_sticky = r_sticky; n_ended = r_ended;
        n_obyte = 8'd0; n_oval = 1'b0; n_ostat = r_sticky;
        dec_en = 1'b0; hist_we = 1'b0; hist_wdata = hist_rdata;
        gam_v = r_field | (32'd1 << r_bitpos[4:0]);
        lit_ctx = {r_ctx[7:0], dec_bit};
        end_count = {1'b0, r_produced} + {1'b0, gam_v};

        if (r_busy && r_sticky == ST_WORKING && r_func != FN_NOP) begin
            case (r_func)
                FN_BYTE: begin
                    if (r_ended || r_coder >= REFILL_LIMIT) begin
                        n_ostat = ST_DROPPED;
                    end else begin
                        n_coder = {r_coder[11:0], r_byte};
                        n_ostat = (n_coder < REFILL_LIMIT) ? ST_NEED_BYTE : ST_WORKING;
                    end
                end
                FN_END: begin
                    n_ended = 1'b1;
                    if (r_phase != PH_COPY && r_coder < REFILL_LIMIT) begin
                        n_sticky = ST_EARLY_END;
                    end
                    n_ostat = n_sticky;
                end
                default: begin
                    if (r_phase == PH_COPY) begin
                        n_obyte = hist_rdata;
                        n_oval = 1'b1;
                        hist_we = 1'b1;
                        n_produced = r_produced + 32'd1;
                        n_wptr = (r_wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                        n_remain = r_remain - 32'd1;
                        if (r_remain == 32'd1) begin
                            n_phase = PH_ISMATCH;
                        end
                        n_ostat = ST_WORKING;
                    end else if (r_coder < REFILL_LIMIT) begin
                        if (r_ended) begin
                            n_sticky = ST_EARLY_END;
                        end
                        n_ostat = r_ended ? ST_EARLY_END : ST_NEED_BYTE;
                    end else begin
                        dec_en = 1'b1;
                        if (dec_bit) begin
                            n_coder = product[19:0] + {12'd0, low};
                        end else begin
                            n_coder = product[19:0] + {12'd0, low} - {12'd0, p};
                        end
                        case (r_phase)
                            PH_ISMATCH: begin
                                if (dec_bit) begin
                                    if (r_prev_match) begin
                                        n_ctx = CX_DIST_BASE; n_field = '0; n_bitpos = '0;
                                        n_phase = PH_OFF_CONT;
                                    end else begin
                                        n_phase = PH_NEWOFF;
                                    end
                                end else begin
                                    n_ctx = 9'd1;
                                    n_phase = PH_LIT;
                                end
                            end
                            PH_NEWOFF: begin
                                n_field = '0; n_bitpos = '0;
                                n_ctx = dec_bit ? CX_DIST_BASE : CX_RUN_BASE;
                                n_phase = dec_bit ? PH_OFF_CONT : PH_LEN_CONT;
                            end
                            PH_LIT: begin
                                n_ctx = lit_ctx;
                                if (lit_ctx[8]) begin
                                    if (r_produced >= r_limit) begin
                                        n_sticky = ST_SIZE;
                                    end else begin
                                        n_obyte = lit_ctx[7:0];
                                        n_oval = 1'b1;
                                        hist_we = 1'b1;
                                        hist_wdata = lit_ctx[7:0];
                                        n_produced = r_produced + 32'd1;
                                        n_wptr = (r_wptr == AW'(HISTORY_DEPTH - 1)) ?
                                                 '0 : r_wptr + 1'b1;
                                        n_prev_match = 1'b0;
                                        n_phase = PH_ISMATCH;
                                    end
                                end
                            end
                            PH_OFF_CONT, PH_LEN_CONT: begin
                                if (dec_bit) begin
                                    n_phase = (r_phase == PH_OFF_CONT) ? PH_OFF_VAL : PH_LEN_VAL;
                                end else if (r_phase == PH_OFF_CONT) begin
                                    if (gam_v == 32'd1) begin
                                        n_sticky = ST_FINISHED;
                                    end else begin
                                        n_offset = gam_v - 32'd1;
                                        n_off_known = 1'b1;
                                        n_ctx = CX_RUN_BASE; n_field = '0; n_bitpos = '0;
                                        n_phase = PH_LEN_CONT;
                                    end
                                end else if (!r_off_known || r_offset > r_produced ||
                                             r_offset > DEPTH_32) begin
                                    n_sticky = ST_OFFSET;
                                end else if (end_count > {1'b0, r_limit}) begin
                                    n_sticky = ST_SIZE;
                                end else begin
                                    n_remain = gam_v;
                                    n_prev_match = 1'b1;
                                    n_phase = PH_COPY;
                                end
                            end
                            PH_OFF_VAL, PH_LEN_VAL: begin
                                n_field = r_field | ({31'd0, dec_bit} << r_bitpos[4:0]);
                                n_bitpos = r_bitpos + 6'd1;
                                if (n_bitpos >= 6'd32) begin
                                    n_sticky = ST_LENGTH;
                                end else begin
                                    n_ctx = r_ctx + 9'd2;
                                    n_phase = (r_phase == PH_OFF_VAL) ? PH_OFF_CONT : PH_LEN_CONT;
                                end
                            end
                            default: n_phase = PH_ISMATCH;
                        endcase
                        n_ostat = n_sticky;
                        if (n_sticky != ST_WORKING) begin
                            n_obyte = 8'd0;
                            n_oval = 1'b0;
                            hist_we = 1'b0;
                        end
                    end
                end
            endcase
        end

        prob_we    = !r_clr_done || dec_en;
        prob_waddr = r_clr_done ? r_prob_addr : r_clr_cnt;
        prob_wdata = r_clr_done ? new_p : PROB_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prob_addr <= prob_raddr;
            r_func <= t_func'(i_func);
            r_byte <= i_in_byte;
        end
        if (r_busy) begin
            r_obyte <= n_obyte;
            r_oval  <= n_oval;
            r_ostat <= n_ostat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_coder <= '0; r_produced <= '0; r_wptr <= '0; r_offset <= '0;
            r_off_known <= 1'b0; r_prev_match <= 1'b0; r_phase <= PH_ISMATCH;
            r_ctx <= '0; r_field <= '0; r_bitpos <= '0; r_remain <= '0;
            r_sticky <= ST_WORKING; r_ended <= 1'b0;
            r_busy <= 1'b0; r_res_valid <= 1'b0;
            r_clr_done <= 1'b0; r_clr_cnt <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_LAST) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (r_busy) begin
                r_coder <= n_coder; r_produced <= n_produced; r_wptr <= n_wptr;
                r_offset <= n_offset; r_off_known <= n_off_known;
                r_prev_match <= n_prev_match; r_phase <= n_phase; r_ctx <= n_ctx;
                r_field <= n_field; r_bitpos <= n_bitpos; r_remain <= n_remain;
                r_sticky <= n_sticky; r_ended <= n_ended;
                r_res_valid <= 1'b1;
            end else if (r_res_valid && !i_res_stall) begin
                r_res_valid <= 1'b0;
            end
            r_busy <= accept;
        end
    end

    `ASSERT_IMPLIES(a_no_cmd_in_clear, i_clk, i_rst_n, !r_clr_done, !accept, "command during clear")
    `ASSERT_NEXT(a_busy_gives_result, i_clk, i_rst_n, r_busy, r_res_valid, "missing result word")
    `ASSERT_NEXT(a_sticky_holds, i_clk, i_rst_n, r_sticky != ST_WORKING, r_sticky == $past(r_sticky), "sticky status changed")
endmodule
`default_nettype wire
